// ----- rtl/core/spi_master_handshake_lsb_first_defines.svh -----
// assertion macros shared by the spi master rtl
`ifndef SPI_MASTER_HANDSHAKE_LSB_FIRST_DEFINES_SVH
`define SPI_MASTER_HANDSHAKE_LSB_FIRST_DEFINES_SVH

`ifndef SYNTHESIS
`define SPIM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPIM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SPIM_ASSERT(name, prop, msg)
`define SPIM_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ----- rtl/core/spim_pkg.sv -----
// types and constants for the spi master
package spim_pkg;

  localparam int unsigned BitsPerWord = 8;
  localparam int unsigned BitW        = $clog2(BitsPerWord);
  localparam int unsigned HalfW       = 10;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  localparam logic             IdleLevelRst = 1'b0;
  localparam logic [HalfW-1:0] HalfTicksRst = HalfW'(10);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHAKE,
    PH_FIRST,
    PH_SECOND
  } phase_e;

  typedef enum logic {
    REG_IDLE_LEVEL = 1'b0,
    REG_HALF_TICKS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             idle_we;
    logic             half_we;
    logic             idle_val;
    logic [HalfW-1:0] half_val;
  } cfg_wr_t;

  typedef struct packed {
    logic                   sck;
    logic                   mosi;
    logic                   cs_n;
    logic                   busy_res;
    logic [BitsPerWord-1:0] rx_data;
    logic                   rx_valid;
  } res_t;

endpackage

// ----- rtl/core/spim_engine.sv -----
// bus state, config registers and per-tick next-state logic
`include "spi_master_handshake_lsb_first_defines.svh"

module spim_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spim_pkg::cfg_wr_t                   cfg_i,
  input  logic                                step_i,
  input  logic                                start_req_i,
  input  logic                                func_i,
  input  logic                                new_transfer_i,
  input  logic [spim_pkg::BitsPerWord-1:0]    tx_data_i,
  input  logic                                miso_i,
  input  logic                                release_req_i,
  output spim_pkg::res_t                      res_o,
  output logic                                idle_level_o,
  output logic [spim_pkg::HalfW-1:0]          half_ticks_o
);
  import spim_pkg::*;

  logic             idle_q;
  logic [HalfW-1:0] half_q;

  logic                   sck_q, sck_d;
  logic                   mosi_q, mosi_d;
  logic                   sel_q, sel_d;
  phase_e                 phase_q, phase_d;
  logic                   recv_q, recv_d;
  logic [BitW-1:0]        bit_q, bit_d;
  logic [HalfW-1:0]       tick_q, tick_d;
  logic [BitsPerWord-1:0] shift_q, shift_d;

  logic                   rx_valid;
  logic [BitsPerWord-1:0] rx_data;
  logic [HalfW-1:0]       half_len;
  logic                   half_done;
  logic                   begin_bit;

  // a zero half period behaves as one tick
  assign half_len  = (half_q == '0) ? HalfW'(1) : half_q;
  assign half_done = (tick_q >= half_len);

  always_comb begin
    sck_d     = sck_q;
    mosi_d    = mosi_q;
    sel_d     = sel_q;
    phase_d   = phase_q;
    recv_d    = recv_q;
    bit_d     = bit_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    rx_valid  = 1'b0;
    rx_data   = '0;
    begin_bit = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          sel_d   = 1'b0;
          recv_d  = func_i;
          shift_d = func_i ? '0 : tx_data_i;
          bit_d   = '0;
          tick_d  = '0;
          if (new_transfer_i) begin
            mosi_d  = func_i;
            phase_d = PH_SHAKE;
          end else begin
            begin_bit = 1'b1;
          end
        end else if (release_req_i) begin
          sel_d = 1'b1;
        end
      end
      PH_SHAKE: begin
        // wait for the slave to echo the announced direction
        if (miso_i == recv_q) begin
          begin_bit = 1'b1;
        end
      end
      PH_FIRST: begin
        if (half_done) begin
          if (recv_q) begin
            shift_d = {miso_i, shift_q[BitsPerWord-1:1]};
          end
          sck_d   = idle_q;
          tick_d  = HalfW'(1);
          phase_d = PH_SECOND;
        end else begin
          tick_d = tick_q + HalfW'(1);
        end
      end
      PH_SECOND: begin
        if (half_done) begin
          if (!recv_q) begin
            shift_d = shift_q >> 1;
          end
          if (bit_q == BitW'(BitsPerWord - 1)) begin
            phase_d = PH_IDLE;
            sck_d   = idle_q;
            tick_d  = '0;
            bit_d   = '0;
            if (recv_q) begin
              rx_valid = 1'b1;
              rx_data  = shift_d;
            end
          end else begin
            bit_d     = bit_q + BitW'(1);
            begin_bit = 1'b1;
          end
        end else begin
          tick_d = tick_q + HalfW'(1);
        end
      end
      default: ;
    endcase

    if (begin_bit) begin
      if (!recv_d) begin
        mosi_d = shift_d[0];
      end
      sck_d   = ~idle_q;
      tick_d  = HalfW'(1);
      phase_d = PH_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q  <= IdleLevelRst;
      half_q  <= HalfTicksRst;
      sck_q   <= IdleLevelRst;
      mosi_q  <= 1'b0;
      sel_q   <= 1'b1;
      phase_q <= PH_IDLE;
      recv_q  <= 1'b0;
      bit_q   <= '0;
      tick_q  <= '0;
      shift_q <= '0;
    end else begin
      if (cfg_i.half_we) begin
        half_q <= cfg_i.half_val;
      end
      if (cfg_i.idle_we) begin
        idle_q <= cfg_i.idle_val;
        // a new idle level moves sck at once except in a first half
        if (phase_q != PH_FIRST) begin
          sck_q <= cfg_i.idle_val;
        end
      end else if (step_i) begin
        sck_q <= sck_d;
      end
      if (step_i) begin
        mosi_q  <= mosi_d;
        sel_q   <= sel_d;
        phase_q <= phase_d;
        recv_q  <= recv_d;
        bit_q   <= bit_d;
        tick_q  <= tick_d;
        shift_q <= shift_d;
      end
    end
  end

  always_comb begin
    res_o.sck      = sck_d;
    res_o.mosi     = mosi_d;
    res_o.cs_n     = sel_d;
    res_o.busy_res = (phase_d != PH_IDLE);
    res_o.rx_data  = rx_data;
    res_o.rx_valid = rx_valid;
  end

  assign idle_level_o = idle_q;
  assign half_ticks_o = half_q;

  `SPIM_ASSERT(a_idle_counters_clear,
      (phase_q == PH_IDLE) |-> (tick_q == '0 && bit_q == '0),
      "counters not cleared while idle")
  `SPIM_ASSERT(a_busy_selected,
      (phase_q != PH_IDLE) |-> !sel_q,
      "chip select high during a byte")
  `SPIM_ASSERT(a_half_tick_nonzero,
      (phase_q == PH_FIRST || phase_q == PH_SECOND) |-> (tick_q != '0),
      "half period counter at zero inside a bit")

endmodule

// ----- rtl/core/spi_master_handshake_lsb_first.sv -----
// Tick-driven SPI master, LSB first. Every input beat is one timing tick: it carries the MISO
// sample and optionally a byte command or a chip-select release, and yields exactly one output
// beat with the pin levels (sck, mosi, cs_n), busy flag and any byte received on that tick.
// A beat is taken every clock when in_stall_o is low; its result is stored in the output
// register or, on a stall, the skid register. The next-state logic is a single short pass from
// the bus state registers to the result register, and a two-entry output stage (result
// register plus skid register) lets the input keep flowing for one beat after the output
// stalls. APB registers: idle clock level at 0x0, half period in ticks at 0x4 (0 acts as 1).
`include "spi_master_handshake_lsb_first_defines.svh"

module spi_master_handshake_lsb_first (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spim_pkg::ApbAddrW-1:0]       paddr,
  input  logic [spim_pkg::ApbDataW-1:0]       pwdata,
  output logic [spim_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready,
  // tick input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                start_req_i,
  input  logic                                func_i,
  input  logic                                new_transfer_i,
  input  logic [spim_pkg::BitsPerWord-1:0]    tx_data_i,
  input  logic                                miso_i,
  input  logic                                release_req_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                sck_o,
  output logic                                mosi_o,
  output logic                                cs_n_o,
  output logic                                busy_res_o,
  output logic [spim_pkg::BitsPerWord-1:0]    rx_data_o,
  output logic                                rx_valid_o
);
  import spim_pkg::*;

  cfg_wr_t          cfg_wr;
  reg_idx_e         reg_idx;
  logic             wr_en;
  logic             idle_level;
  logic [HalfW-1:0] half_ticks;

  res_t res;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_valid_q, out_valid_d;
  logic skid_full_q, skid_full_d;
  logic accept;
  logic out_free;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_wr.idle_we  = wr_en && (reg_idx == REG_IDLE_LEVEL);
    cfg_wr.half_we  = wr_en && (reg_idx == REG_HALF_TICKS);
    cfg_wr.idle_val = pwdata[0];
    cfg_wr.half_val = pwdata[HalfW-1:0];
  end

  always_comb begin
    unique case (reg_idx)
      REG_IDLE_LEVEL: prdata = ApbDataW'(idle_level);
      REG_HALF_TICKS: prdata = ApbDataW'(half_ticks);
      default:        prdata = '0;
    endcase
  end

  assign in_stall_o = skid_full_q;
  assign accept     = in_valid_i & ~skid_full_q;

  spim_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_wr),
    .step_i         (accept),
    .start_req_i    (start_req_i),
    .func_i         (func_i),
    .new_transfer_i (new_transfer_i),
    .tx_data_i      (tx_data_i),
    .miso_i         (miso_i),
    .release_req_i  (release_req_i),
    .res_o          (res),
    .idle_level_o   (idle_level),
    .half_ticks_o   (half_ticks)
  );

  // output register is free when empty or its beat leaves this cycle
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_d       = out_q;
    skid_d      = skid_q;
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    if (out_free) begin
      if (skid_full_q) begin
        out_d       = skid_q;
        out_valid_d = 1'b1;
        skid_full_d = 1'b0;
      end else if (accept) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept) begin
      skid_d      = res;
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign sck_o       = out_q.sck;
  assign mosi_o      = out_q.mosi;
  assign cs_n_o      = out_q.cs_n;
  assign busy_res_o  = out_q.busy_res;
  assign rx_data_o   = out_q.rx_data;
  assign rx_valid_o  = out_q.rx_valid;

  `SPIM_ASSERT(a_skid_behind_out,
      skid_full_q |-> out_valid_q,
      "skid register holds a beat while output register is empty")
  `SPIM_ASSERT(a_skid_fill_on_stall,
      $rose(skid_full_q) |-> $past(out_valid_q && out_stall_i),
      "skid register filled without a stalled output")
  `SPIM_ASSERT(a_rx_ends_byte,
      (out_valid_q && out_q.rx_valid) |-> !out_q.busy_res,
      "received byte reported while still busy")
  `SPIM_ASSERT_NEXT(a_drain_skid,
      skid_full_q && !out_stall_i, !skid_full_q,
      "skid register not drained when output moved")

endmodule

// ----- sim/tb_spi_master_handshake_lsb_first.sv -----
// self-checking testbench for the lsb-first spi master with direction handshake
module tb_spi_master_handshake_lsb_first;
  timeunit 1ns;
  timeprecision 1ps;
  import spim_pkg::*;

  typedef struct packed {
    logic       start;
    logic       func;
    logic       new_xfer;
    logic [7:0] tx;
    logic       miso;
    logic       rel;
  } tick_t;

  // tracks the bus master's pins tick by tick and holds the pin levels still owed by the dut
  class spi_pin_tracker;
    logic             idle_level;
    logic [HalfW-1:0] half_ticks;
    logic             sck;
    logic             mosi;
    logic             cs_n;
    phase_e           phase;
    logic             receiving;
    logic [BitW-1:0]  bit_no;
    logic [HalfW-1:0] tick_cnt;
    logic [7:0]       shreg;
    res_t             expected_pins[$];
    int               mismatches;

    function new();
      idle_level = IdleLevelRst;
      half_ticks = HalfTicksRst;
      sck        = IdleLevelRst;
      mosi       = 1'b0;
      cs_n       = 1'b1;
      phase      = PH_IDLE;
      receiving  = 1'b0;
      bit_no     = '0;
      tick_cnt   = '0;
      shreg      = '0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void set_reg(reg_idx_e idx, logic [ApbDataW-1:0] val);
      if (idx == REG_IDLE_LEVEL) begin
        idle_level = val[0];
        // only a first half holds the driven level
        if (phase != PH_FIRST) sck = idle_level;
      end else begin
        half_ticks = val[HalfW-1:0];
      end
    endfunction

    function void start_bit();
      if (!receiving) mosi = shreg[0];
      sck      = ~idle_level;
      tick_cnt = HalfW'(1);
      phase    = PH_FIRST;
    endfunction

    function void note_tick(tick_t t);
      res_t             r;
      logic [HalfW-1:0] hl;
      hl         = (half_ticks == 0) ? HalfW'(1) : half_ticks;
      r.rx_valid = 1'b0;
      r.rx_data  = '0;
      case (phase)
        PH_IDLE: begin
          if (t.start) begin
            cs_n      = 1'b0;
            receiving = t.func;
            shreg     = t.func ? 8'h00 : t.tx;
            bit_no    = '0;
            tick_cnt  = '0;
            if (t.new_xfer) begin
              mosi  = t.func;
              phase = PH_SHAKE;
            end else begin
              start_bit();
            end
          end else if (t.rel) begin
            cs_n = 1'b1;
          end
        end
        PH_SHAKE: begin
          if (t.miso == receiving) start_bit();
        end
        PH_FIRST: begin
          if (tick_cnt >= hl) begin
            if (receiving) shreg = {t.miso, shreg[7:1]};
            sck      = idle_level;
            tick_cnt = HalfW'(1);
            phase    = PH_SECOND;
          end else begin
            tick_cnt++;
          end
        end
        default: begin
          if (tick_cnt >= hl) begin
            if (!receiving) shreg = shreg >> 1;
            if (bit_no == BitW'(BitsPerWord - 1)) begin
              phase    = PH_IDLE;
              sck      = idle_level;
              tick_cnt = '0;
              bit_no   = '0;
              if (receiving) begin
                r.rx_valid = 1'b1;
                r.rx_data  = shreg;
              end
            end else begin
              bit_no++;
              start_bit();
            end
          end else begin
            tick_cnt++;
          end
        end
      endcase
      r.sck      = sck;
      r.mosi     = mosi;
      r.cs_n     = cs_n;
      r.busy_res = (phase != PH_IDLE);
      expected_pins.push_back(r);
    endfunction

    task check_pins(res_t got);
      res_t e;
      if (expected_pins.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = expected_pins.pop_front();
      if (got.sck !== e.sck)
        report($sformatf("sck expected %0b got %0b", e.sck, got.sck));
      if (got.mosi !== e.mosi)
        report($sformatf("mosi expected %0b got %0b", e.mosi, got.mosi));
      if (got.cs_n !== e.cs_n)
        report($sformatf("cs_n expected %0b got %0b", e.cs_n, got.cs_n));
      if (got.busy_res !== e.busy_res)
        report($sformatf("busy_res expected %0b got %0b", e.busy_res, got.busy_res));
      if (got.rx_data !== e.rx_data)
        report($sformatf("rx_data expected %02h got %02h", e.rx_data, got.rx_data));
      if (got.rx_valid !== e.rx_valid)
        report($sformatf("rx_valid expected %0b got %0b", e.rx_valid, got.rx_valid));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrW-1:0]    paddr;
  logic [ApbDataW-1:0]    pwdata;
  logic [ApbDataW-1:0]    prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   start_req_i;
  logic                   func_i;
  logic                   new_transfer_i;
  logic [BitsPerWord-1:0] tx_data_i;
  logic                   miso_i;
  logic                   release_req_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   sck_o;
  logic                   mosi_o;
  logic                   cs_n_o;
  logic                   busy_res_o;
  logic [BitsPerWord-1:0] rx_data_o;
  logic                   rx_valid_o;

  spi_pin_tracker sb;
  bit             no_gaps;
  bit             hold_pending;

  spi_master_handshake_lsb_first dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_req_i    (start_req_i),
    .func_i         (func_i),
    .new_transfer_i (new_transfer_i),
    .tx_data_i      (tx_data_i),
    .miso_i         (miso_i),
    .release_req_i  (release_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sck_o          (sck_o),
    .mosi_o         (mosi_o),
    .cs_n_o         (cs_n_o),
    .busy_res_o     (busy_res_o),
    .rx_data_o      (rx_data_o),
    .rx_valid_o     (rx_valid_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("** spi_master_handshake_lsb_first: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_pins(res_t'({sck_o, mosi_o, cs_n_o, busy_res_o, rx_data_o, rx_valid_o}));
  end

  // result side: random stall bursts, plus one long hold-off to back the block up
  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = 64;
      end else if (stall_left == 0 && !no_gaps && rst_ni && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic tick_t mk(logic start, logic func, logic new_xfer, logic [7:0] tx,
                               logic miso, logic rel);
    tick_t t;
    t.start    = start;
    t.func     = func;
    t.new_xfer = new_xfer;
    t.tx       = tx;
    t.miso     = miso;
    t.rel      = rel;
    return t;
  endfunction

  // behaves like a slave: commands likelier when idle, mostly echoes the direction in handshake
  function automatic tick_t make_tick();
    tick_t t;
    t.func     = 1'($urandom_range(0, 1));
    t.new_xfer = 1'($urandom_range(0, 1));
    t.tx       = 8'($urandom_range(0, 255));
    t.miso     = 1'($urandom_range(0, 1));
    case (sb.phase)
      PH_IDLE: begin
        t.start = ($urandom_range(0, 2) == 0);
        t.rel   = ($urandom_range(0, 5) == 0);
      end
      PH_SHAKE: begin
        t.start = ($urandom_range(0, 7) == 0);
        t.rel   = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 2) == 0) t.miso = sb.receiving;
      end
      default: begin
        t.start = ($urandom_range(0, 7) == 0);
        t.rel   = ($urandom_range(0, 7) == 0);
      end
    endcase
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    @(negedge clk_i);
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    start_req_i    <= t.start;
    func_i         <= t.func;
    new_transfer_i <= t.new_xfer;
    tx_data_i      <= t.tx;
    miso_i         <= t.miso;
    release_req_i  <= t.rel;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(t);
  endtask

  task automatic run_until_idle();
    while (sb.phase != PH_IDLE) send_tick(make_tick());
  endtask

  // registers change only with no beat in flight; each write is read back
  task automatic write_reg(reg_idx_e idx, int unsigned val);
    logic [ApbDataW-1:0] rd;
    logic [ApbDataW-1:0] want;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * int'(idx));
    pwdata  <= ApbDataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, ApbDataW'(val));
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (idx == REG_IDLE_LEVEL) ? ApbDataW'(sb.idle_level) : ApbDataW'(sb.half_ticks);
    if (rd !== want)
      sb.report($sformatf("register %s read %0h expected %0h", idx.name(), rd, want));
  endtask

  initial begin
    int unsigned lvl_set  [6];
    int unsigned half_set [6];
    int unsigned count_set[6];
    int          guard;
    lvl_set        = '{0, 1, 0, 1, 0, 1};
    half_set       = '{1, 2, 0, 3, 7, 1};
    count_set      = '{140, 140, 110, 140, 110, 110};
    sb             = new();
    no_gaps        = 1'b0;
    hold_pending   = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    start_req_i    = 1'b0;
    func_i         = 1'b0;
    new_transfer_i = 1'b0;
    tx_data_i      = '0;
    miso_i         = 1'b0;
    release_req_i  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: command and release together, then an ignored command and release
    send_tick(mk(1, 0, 0, 8'hFF, 0, 1));
    send_tick(mk(1, 1, 1, 8'h00, 1, 1));
    run_until_idle();
    write_reg(REG_HALF_TICKS, 0);
    send_tick(mk(0, 0, 0, 8'h00, 0, 1));
    // receive with handshake, echo withheld for two ticks
    send_tick(mk(1, 1, 1, 8'h5A, 0, 0));
    send_tick(mk(0, 0, 0, 8'h00, 0, 0));
    send_tick(mk(0, 0, 0, 8'h00, 0, 0));
    send_tick(mk(0, 0, 0, 8'h00, 1, 0));
    run_until_idle();
    // transmit with handshake
    send_tick(mk(1, 0, 1, 8'h00, 1, 0));
    send_tick(mk(0, 0, 0, 8'hFF, 1, 0));
    send_tick(mk(0, 0, 0, 8'hFF, 0, 0));
    run_until_idle();
    // settings moved in the middle of a byte, landing in both halves
    send_tick(mk(1, 0, 0, 8'hA5, 0, 0));
    send_tick(mk(0, 0, 0, 8'h00, 1, 0));
    send_tick(mk(0, 0, 0, 8'h00, 0, 0));
    write_reg(REG_IDLE_LEVEL, 1);
    send_tick(mk(0, 0, 0, 8'h00, 1, 0));
    write_reg(REG_IDLE_LEVEL, 0);
    send_tick(mk(0, 0, 0, 8'h00, 0, 0));
    write_reg(REG_HALF_TICKS, 1);
    run_until_idle();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) no_gaps = 1'b1;
      write_reg(REG_IDLE_LEVEL, lvl_set[p]);
      write_reg(REG_HALF_TICKS, half_set[p]);
      // long hold-off while beats keep coming
      if (p == 0) hold_pending = 1'b1;
      repeat (count_set[p]) send_tick(make_tick());
    end
    run_until_idle();

    // a receive byte at the longest half period, cut short in its first half
    write_reg(REG_IDLE_LEVEL, 1);
    write_reg(REG_HALF_TICKS, 1023);
    send_tick(mk(1, 1, 0, 8'h00, 0, 0));
    repeat (100) send_tick(mk(0, 0, 0, 8'h00, 1, 0));
    write_reg(REG_HALF_TICKS, 1);
    run_until_idle();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.expected_pins.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.expected_pins.size() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.expected_pins.size()));
    if (sb.mismatches == 0) begin
      $display("** spi_master_handshake_lsb_first: PASSED **");
    end else begin
      $display("** spi_master_handshake_lsb_first: FAILED **");
    end
    $finish;
  end

endmodule
